### design/multi_pattern_nibble_prefilter_match_assert.svh
// Assertion helpers used by the checker file.
`ifndef MULTI_PATTERN_NIBBLE_PREFILTER_MATCH_ASSERT_SVH
`define MULTI_PATTERN_NIBBLE_PREFILTER_MATCH_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PMNPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PMNPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pmnpm_pkg.sv
package pmnpm_pkg;

  localparam int NUM_BUCKETS         = 16;
  localparam int PATTERNS_PER_BUCKET = 16;
  localparam int MAX_PATTERN_LEN     = 16;
  localparam int POSITION_WIDTH      = 32;

  localparam int SLOT_CAPACITY = NUM_BUCKETS * PATTERNS_PER_BUCKET;
  localparam int SLOT_W        = 8;
  localparam int CNT_W         = 9;
  localparam int LEN_W         = 5;
  localparam int OFF_W         = 4;
  localparam int BKT_W         = 4;

  // request opcodes
  localparam logic [1:0] OP_PAT_BYTE = 2'd0;
  localparam logic [1:0] OP_PAT_LEN  = 2'd1;
  localparam logic [1:0] OP_TEXT     = 2'd2;

  typedef logic [7:0] byte_t;
  typedef byte_t [MAX_PATTERN_LEN-1:0] row_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [SLOT_W-1:0] pattern_slot;
    logic [OFF_W-1:0] byte_offset;
    logic [7:0]       data_byte;
    logic             last_of_text;
  } in_req_t;

  typedef struct packed {
    logic                      found;
    logic [SLOT_W-1:0]         pattern_number;
    logic [POSITION_WIDTH-1:0] match_start;
    logic [POSITION_WIDTH-1:0] match_end;
  } out_res_t;

  // nibble map update
  typedef struct packed {
    logic             en;
    logic [BKT_W-1:0] bucket;
    logic [7:0]       data;
  } map_wr_t;

  // pattern table write
  typedef struct packed {
    logic              en;
    logic              len_en;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  lane;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
  } pat_wr_t;

endpackage

### design/multi_pattern_nibble_prefilter_match.sv
// Multi-pattern search with a nibble prefilter, 16 buckets of 16 patterns.
// Requests: drive in_data and pulse start; a request is taken when start is
// high and busy is low. Ops load a pattern byte, load a pattern length, or
// stream one text byte (last_of_text closes the search).
// Loads, and text bytes that decide no start, leave busy low.
// A deciding text byte raises busy; an alignment state then shifts the
// check row F bytes. F is 0 on a full window and 16 minus the fill at the
// last byte of a short text. Each start is then walked: a row read for each
// pattern in a candidate bucket, a skip over each bucket that is not a
// candidate, then the last read returns and the start closes; a hit ends the
// walk. A start with no candidate bucket closes without a read. At the last
// byte up to 16 starts are walked in turn, the check row shifting between them.
// Results: out_valid is high for one cycle with out_data, one result at most
// per text byte (a match, or found=0 at the last byte), registered from the
// deciding compare. The receiver cannot stall; results are simply presented.
// Config: APB register 0 (pattern_count) at address 0; cfg_pready is tied high.
// Reset: nibble maps, search window, position and count clear at once; the
// pattern table is undefined until loaded. No clearing pass.
module multi_pattern_nibble_prefilter_match (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pmnpm_pkg::in_req_t  in_data,
  output logic                out_valid,
  output pmnpm_pkg::out_res_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import pmnpm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  localparam logic [LEN_W-1:0] FULL = LEN_W'(MAX_PATTERN_LEN);

  logic [1:0]                state_r;
  row_t                      win_r, chk_r;
  logic [LEN_W-1:0]          fill_r;
  logic [POSITION_WIDTH-1:0] pos_r, cur_pos_r;
  logic                      reported_r, last_r;
  logic [CNT_W-1:0]          cnt_r, p_r;
  logic [OFF_W-1:0]          o_r, first_r;
  logic                      rd_v_r;
  logic [SLOT_W-1:0]         rd_p_r;
  logic                      out_valid_r;
  out_res_t                  out_r;

  logic                      acc, cfg_wr;
  row_t                      win_nxt;
  logic [LEN_W-1:0]          fill_nxt;
  logic [CNT_W-1:0]          cnt_eff;
  logic [NUM_BUCKETS-1:0]    cand;
  logic                      p_live, issue, hit, bytes_ok;
  logic [LEN_W-1:0]          avail;
  row_t                      rd_row;
  logic [LEN_W-1:0]          rd_len;
  pat_wr_t                   pat_wr;
  map_wr_t                   map_wr;
  logic [POSITION_WIDTH-1:0] start_pos;

  assign acc    = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(cnt_r);

  // loads
  always_comb begin
    pat_wr        = '0;
    pat_wr.slot   = in_data.pattern_slot;
    pat_wr.lane   = in_data.byte_offset;
    pat_wr.data   = in_data.data_byte;
    pat_wr.len    = (in_data.data_byte > 8'(MAX_PATTERN_LEN)) ? FULL
                                                                : in_data.data_byte[LEN_W-1:0];
    pat_wr.en     = acc && (in_data.op == OP_PAT_BYTE);
    pat_wr.len_en = acc && (in_data.op == OP_PAT_LEN);
    map_wr.en     = pat_wr.en && (in_data.byte_offset == '0);
    map_wr.bucket = in_data.pattern_slot[SLOT_W-1 -: BKT_W];
    map_wr.data   = in_data.data_byte;
  end

  // window shift on a text byte
  assign win_nxt  = row_t'({in_data.data_byte, win_r[MAX_PATTERN_LEN-1:1]});
  assign fill_nxt = (fill_r == FULL) ? FULL : fill_r + LEN_W'(1);
  assign cnt_eff  = (cnt_r > CNT_W'(SLOT_CAPACITY)) ? CNT_W'(SLOT_CAPACITY) : cnt_r;

  // candidate walk
  assign p_live = (p_r < cnt_eff) && (cand != '0);
  assign issue  = (state_r == ST_SCAN) && p_live && cand[p_r[SLOT_W-1 -: BKT_W]];

  pmnpm_prefilter u_pf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (map_wr),
    .look_byte (chk_r[0]),
    .cand      (cand)
  );

  pmnpm_pat_ram u_ram (
    .clk     (clk),
    .wr      (pat_wr),
    .rd_en   (issue),
    .rd_addr (p_r[SLOT_W-1:0]),
    .rd_row  (rd_row),
    .rd_len  (rd_len)
  );

  // exact compare of the fetched row
  assign avail = FULL - LEN_W'(o_r);
  always_comb begin
    bytes_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      if ((LEN_W'(i) < rd_len) && (chk_r[i] != rd_row[i])) bytes_ok = 1'b0;
    end
  end
  assign hit = rd_v_r && (rd_len != '0) && (rd_len <= avail) && bytes_ok;

  assign start_pos = cur_pos_r - POSITION_WIDTH'(MAX_PATTERN_LEN - 1) + POSITION_WIDTH'(o_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      reported_r  <= 1'b0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr && !cfg_paddr[2]) cnt_r <= cfg_pwdata[CNT_W-1:0];
      case (state_r)
        ST_IDLE: begin
          if (acc && (in_data.op == OP_TEXT)) begin
            if (reported_r) begin
              if (in_data.last_of_text) begin
                win_r      <= '0;
                fill_r     <= '0;
                pos_r      <= '0;
                reported_r <= 1'b0;
              end
            end else begin
              win_r     <= win_nxt;
              fill_r    <= fill_nxt;
              pos_r     <= pos_r + POSITION_WIDTH'(1);
              cur_pos_r <= pos_r;
              last_r    <= in_data.last_of_text;
              chk_r     <= win_nxt;
              o_r       <= '0;
              p_r       <= '0;
              first_r   <= (fill_nxt == FULL) ? '0 : OFF_W'(FULL - fill_nxt);
              if ((fill_nxt == FULL) || in_data.last_of_text) state_r <= ST_ALIGN;
            end
          end
        end
        ST_ALIGN: begin
          if (o_r == first_r) begin
            state_r <= ST_SCAN;
          end else begin
            chk_r <= row_t'({8'h00, chk_r[MAX_PATTERN_LEN-1:1]});
            o_r   <= o_r + OFF_W'(1);
          end
        end
        ST_SCAN: begin
          rd_v_r <= issue;
          rd_p_r <= p_r[SLOT_W-1:0];
          if (hit) begin
            rd_v_r                  <= 1'b0;
            out_valid_r             <= 1'b1;
            out_r.found             <= 1'b1;
            out_r.pattern_number    <= rd_p_r;
            out_r.match_start       <= start_pos;
            out_r.match_end         <= start_pos + POSITION_WIDTH'(rd_len);
            state_r                 <= ST_IDLE;
            if (last_r) begin
              win_r  <= '0;
              fill_r <= '0;
              pos_r  <= '0;
            end else begin
              reported_r <= 1'b1;
            end
          end else if (p_live) begin
            if (cand[p_r[SLOT_W-1 -: BKT_W]]) begin
              p_r <= p_r + CNT_W'(1);
            end else begin
              p_r <= {p_r[CNT_W-1 -: CNT_W-BKT_W] + (CNT_W-BKT_W)'(1), BKT_W'(0)};
            end
          end else if (!rd_v_r) begin
            // this start is done without a hit
            if (last_r && (o_r != '1)) begin
              chk_r <= row_t'({8'h00, chk_r[MAX_PATTERN_LEN-1:1]});
              o_r   <= o_r + OFF_W'(1);
              p_r   <= '0;
            end else begin
              state_r <= ST_IDLE;
              if (last_r) begin
                out_valid_r <= 1'b1;
                out_r       <= '0;
                win_r       <= '0;
                fill_r      <= '0;
                pos_r       <= '0;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/pmnpm_pat_ram.sv
module pmnpm_pat_ram (
  input  logic                          clk,
  input  pmnpm_pkg::pat_wr_t            wr,
  input  logic                          rd_en,
  input  logic [pmnpm_pkg::SLOT_W-1:0]  rd_addr,
  output pmnpm_pkg::row_t               rd_row,
  output logic [pmnpm_pkg::LEN_W-1:0]   rd_len
);
  import pmnpm_pkg::*;

  row_t             mem     [SLOT_CAPACITY];
  logic [LEN_W-1:0] len_mem [SLOT_CAPACITY];

  // byte-lane write, registered row read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot][wr.lane] <= wr.data;
    end
    if (wr.len_en) begin
      len_mem[wr.slot] <= wr.len;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
      rd_len <= len_mem[rd_addr];
    end
  end

endmodule

### design/pmnpm_prefilter.sv
module pmnpm_prefilter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pmnpm_pkg::map_wr_t                  wr,
  input  logic [7:0]                          look_byte,
  output logic [pmnpm_pkg::NUM_BUCKETS-1:0]   cand
);
  import pmnpm_pkg::*;

  logic [NUM_BUCKETS-1:0] lo_r [16];
  logic [NUM_BUCKETS-1:0] hi_r [16];
  logic [NUM_BUCKETS-1:0] bit_sel;

  assign bit_sel = NUM_BUCKETS'(1) << wr.bucket;

  // outside reset, bits are only ever set
  always_ff @(posedge clk) begin
    for (int k = 0; k < 16; k++) begin
      if (!rst_n) begin
        lo_r[k] <= '0;
        hi_r[k] <= '0;
      end else if (wr.en) begin
        if (wr.data[3:0] == 4'(k)) lo_r[k] <= lo_r[k] | bit_sel;
        if (wr.data[7:4] == 4'(k)) hi_r[k] <= hi_r[k] | bit_sel;
      end
    end
  end

  assign cand = lo_r[look_byte[3:0]] & hi_r[look_byte[7:4]];

endmodule

### design/pmnpm_chk.sv
`include "multi_pattern_nibble_prefilter_match_assert.svh"

module pmnpm_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input pmnpm_pkg::in_req_t  in_data,
  input logic                out_valid,
  input pmnpm_pkg::out_res_t out_data
);
  import pmnpm_pkg::*;

  // results are single-cycle strobes, never back to back
  `PMNPM_ASSERT_NEXT(a_strobe, out_valid, !out_valid, "back-to-back results")
  // a result ends the work on its request
  `PMNPM_ASSERT_NOW(a_idle_at_result, out_valid, !busy, "busy while presenting result")
  // no-match result carries zero fields
  `PMNPM_ASSERT_NOW(a_nomatch_zero, out_valid && !out_data.found, (out_data.pattern_number == '0) && (out_data.match_start == '0) && (out_data.match_end == '0), "nonzero fields without match")
  // match length is 1..MAX_PATTERN_LEN
  `PMNPM_ASSERT_NOW(a_len, out_valid && out_data.found, ((out_data.match_end - out_data.match_start) != '0) && ((out_data.match_end - out_data.match_start) <= POSITION_WIDTH'(MAX_PATTERN_LEN)), "match length out of range")
  // a load never leaves the block busy
  `PMNPM_ASSERT_NEXT(a_load_fast, start && !busy && (in_data.op != OP_TEXT), !busy, "load left block busy")

endmodule

bind multi_pattern_nibble_prefilter_match pmnpm_chk u_pmnpm_chk (.*);

### tb/multi_pattern_nibble_prefilter_match_tb.sv
`timescale 1ns / 100ps

module multi_pattern_nibble_prefilter_match_tb;
  import pmnpm_pkg::*;

  localparam logic [2:0] REG_PATTERN_COUNT = 3'd0;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_data = '0;
  logic out_valid;
  out_res_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  multi_pattern_nibble_prefilter_match DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // Search model state
  logic [7:0] pat_bytes [SLOT_CAPACITY][MAX_PATTERN_LEN];
  logic [4:0] pat_len [SLOT_CAPACITY];
  logic [15:0] lo_map [16];
  logic [15:0] hi_map [16];
  logic [7:0] window [MAX_PATTERN_LEN];
  int unsigned win_fill;
  logic [31:0] text_pos;
  bit reported;
  logic [8:0] pat_count;

  // Which pattern bytes the test has loaded, so no unwritten byte is read
  bit [MAX_PATTERN_LEN-1:0] loaded_mask [SLOT_CAPACITY];
  int live_slots[$];

  out_res_t search_results_q[$];
  int idle_pct = 0;
  int errors = 0;
  int n_reqs = 0, n_found = 0, n_nomatch = 0;

  function automatic void clear_search();
    foreach (window[i]) window[i] = 8'h00;
    win_fill = 0;
    text_pos = '0;
    reported = 1'b0;
  endfunction

  // Lowest matching pattern at window offset o with avail bytes, or -1
  function automatic int match_at(int o, int avail);
    logic [7:0] b;
    logic [15:0] cand;
    int lim;
    bit ok;
    b = window[o];
    cand = lo_map[b[3:0]] & hi_map[b[7:4]];
    lim = (pat_count > SLOT_CAPACITY) ? SLOT_CAPACITY : pat_count;
    if (cand == 0) return -1;
    for (int p = 0; p < lim; p++) begin
      if (!cand[p / PATTERNS_PER_BUCKET]) continue;
      if (pat_len[p] == 0 || pat_len[p] > avail) continue;
      ok = 1'b1;
      for (int i = 0; i < pat_len[p]; i++)
        if (window[o + i] != pat_bytes[p][i]) ok = 1'b0;
      if (ok) return p;
    end
    return -1;
  endfunction

  // Apply one accepted request and queue the result it should produce
  function automatic void search_step(in_req_t r);
    int hit, o, first;
    logic [31:0] pos, s;
    out_res_t res;
    hit = -1;
    o = 0;
    case (r.op)
      OP_PAT_BYTE: begin
        pat_bytes[r.pattern_slot][r.byte_offset] = r.data_byte;
        if (r.byte_offset == 0) begin
          lo_map[r.data_byte[3:0]] |= 16'(1) << (r.pattern_slot / PATTERNS_PER_BUCKET);
          hi_map[r.data_byte[7:4]] |= 16'(1) << (r.pattern_slot / PATTERNS_PER_BUCKET);
        end
      end
      OP_PAT_LEN:
        pat_len[r.pattern_slot] = (r.data_byte > MAX_PATTERN_LEN) ?
                                  5'(MAX_PATTERN_LEN) : r.data_byte[4:0];
      OP_TEXT: begin
        if (reported) begin
          if (r.last_of_text) clear_search();
        end else begin
          pos = text_pos;
          for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) window[i] = window[i + 1];
          window[MAX_PATTERN_LEN - 1] = r.data_byte;
          if (win_fill < MAX_PATTERN_LEN) win_fill++;
          text_pos = text_pos + 1;
          if (win_fill == MAX_PATTERN_LEN) hit = match_at(0, MAX_PATTERN_LEN);
          if (hit < 0 && r.last_of_text) begin
            first = (win_fill == MAX_PATTERN_LEN) ? 1 : MAX_PATTERN_LEN - win_fill;
            for (o = first; o < MAX_PATTERN_LEN; o++) begin
              hit = match_at(o, MAX_PATTERN_LEN - o);
              if (hit >= 0) break;
            end
          end
          if (hit >= 0) begin
            s = pos - 32'(MAX_PATTERN_LEN - 1 - o);
            res.found = 1'b1;
            res.pattern_number = 8'(hit);
            res.match_start = s;
            res.match_end = s + 32'(pat_len[hit]);
            search_results_q.push_back(res);
            if (r.last_of_text) clear_search();
            else reported = 1'b1;
          end else if (r.last_of_text) begin
            search_results_q.push_back('0);
            clear_search();
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Result checker: the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (search_results_q.size() == 0) begin
        $error("unexpected result found=%0d pattern=%0d", out_data.found,
               out_data.pattern_number);
        errors++;
      end else begin
        out_res_t e;
        e = search_results_q.pop_front();
        if (out_data.found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, out_data.found);
          errors++;
        end
        if (out_data.pattern_number !== e.pattern_number) begin
          $error("pattern_number: expected %0d, got %0d", e.pattern_number,
                 out_data.pattern_number);
          errors++;
        end
        if (out_data.match_start !== e.match_start) begin
          $error("match_start: expected %0d, got %0d", e.match_start,
                 out_data.match_start);
          errors++;
        end
        if (out_data.match_end !== e.match_end) begin
          $error("match_end: expected %0d, got %0d", e.match_end, out_data.match_end);
          errors++;
        end
        if (e.found) n_found++;
        else n_nomatch++;
      end
    end
  end

  // Send one request; start stays high unless an idle gap follows
  task automatic send_req(logic [1:0] op, logic [7:0] slot, logic [3:0] off,
                          logic [7:0] data, logic last);
    in_req_t r;
    r.op = op;
    r.pattern_slot = slot;
    r.byte_offset = off;
    r.data_byte = data;
    r.last_of_text = last;
    start <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    search_step(r);
    n_reqs++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop requesting and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (search_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pattern_count(logic [8:0] value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_PATTERN_COUNT;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    pat_count = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_byte(logic [7:0] slot, logic [3:0] off, logic [7:0] data);
    send_req(OP_PAT_BYTE, slot, off, data, 1'b0);
    loaded_mask[slot][off] = 1'b1;
  endtask

  // Load a full pattern then its length (len may exceed 16 to saturate)
  task automatic define_pattern(logic [7:0] slot, int len);
    int n;
    n = (len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len;
    for (int i = 0; i < n; i++) load_byte(slot, 4'(i), 8'($urandom_range(255)));
    send_req(OP_PAT_LEN, slot, 4'($urandom_range(15)), 8'(len), 1'b0);
    if (len > 0) live_slots.push_back(slot);
  endtask

  task automatic send_text(logic [7:0] bytes[$]);
    foreach (bytes[i])
      send_req(OP_TEXT, 8'($urandom_range(255)), 4'($urandom_range(15)), bytes[i],
               i == bytes.size() - 1);
  endtask

  // Text of random filler with copies of loaded patterns, maybe cut short
  task automatic random_text(int max_len);
    logic [7:0] t[$];
    int n, s;
    n = $urandom_range(1, max_len);
    while (t.size() < n) begin
      if (live_slots.size() > 0 && $urandom_range(2) == 0) begin
        s = live_slots[$urandom_range(live_slots.size() - 1)];
        for (int i = 0; i < pat_len[s]; i++)
          if ($urandom_range(15) != 0 || i == 0) t.push_back(pat_bytes[s][i]);
          else t.push_back(8'($urandom_range(255)));
      end else begin
        t.push_back(8'($urandom_range(255)));
      end
    end
    while (t.size() > n) void'(t.pop_back());
    send_text(t);
  endtask

  // Noise: stray byte loads, valid length rewrites, unused op
  task automatic random_load();
    logic [7:0] slot;
    int k;
    slot = 8'($urandom_range(255));
    case ($urandom_range(3))
      0, 1: load_byte(slot, 4'($urandom_range(15)), 8'($urandom_range(255)));
      2: begin
        k = 0;
        while (k < MAX_PATTERN_LEN && loaded_mask[slot][k]) k++;
        send_req(OP_PAT_LEN, slot, 4'($urandom_range(15)),
                 8'((k == MAX_PATTERN_LEN) ? $urandom_range(255) : $urandom_range(k)),
                 1'b0);
        if (pat_len[slot] != 0) live_slots.push_back(slot);
      end
      default: send_req(OP_UNUSED, slot, 4'($urandom_range(15)),
                        8'($urandom_range(255)), 1'($urandom_range(1)));
    endcase
  endtask

  // Zero all lengths so every slot is defined; no byte read without a length
  task automatic test_table_init();
    for (int s = 0; s < SLOT_CAPACITY; s++)
      send_req(OP_PAT_LEN, 8'(s), 4'(s), 8'h00, 1'(s));
  endtask

  task automatic test_directed();
    logic [7:0] t[$];
    // empty maps: no match at end of a one-byte text
    t = '{8'h00};
    send_text(t);
    define_pattern(8'd0, 2);
    define_pattern(8'd255, 16);
    define_pattern(8'd32, 200);
    define_pattern(8'd17, 0);
    load_byte(8'd17, 4'd15, 8'hff);
    send_req(OP_UNUSED, 8'hff, 4'hf, 8'hff, 1'b1);
    write_pattern_count(9'd256);
    // short match, then text after a match
    t = '{8'h11, pat_bytes[0][0], pat_bytes[0][1], 8'h22, pat_bytes[0][0], 8'h33};
    send_text(t);
    // longest pattern, decided by a full window
    t = '{};
    for (int i = 0; i < 16; i++) t.push_back(pat_bytes[255][i]);
    t.push_back(8'hee);
    send_text(t);
    // match cut off by the end of text
    t = '{pat_bytes[255][0], pat_bytes[255][1], pat_bytes[255][2]};
    send_text(t);
    t = '{8'hff};
    send_text(t);
  endtask

  task automatic test_count_settings();
    logic [8:0] counts[4] = '{9'd0, 9'd1, 9'd511, 9'd256};
    foreach (counts[c]) begin
      write_pattern_count(counts[c]);
      repeat (4) random_text(20);
    end
  endtask

  task automatic test_random(int n_iter, int pct);
    idle_pct = pct;
    for (int i = 0; i < n_iter; i++) begin
      if ($urandom_range(4) == 0) random_load();
      else if ($urandom_range(30) == 0) random_text(60);
      else random_text(12);
    end
    idle_pct = 0;
  endtask

  task automatic test_pause_then_resume();
    drain();
    for (int i = 0; i < 16; i++) define_pattern(8'($urandom_range(255)),
                                                $urandom_range(1, 16));
    write_pattern_count(9'($urandom_range(1, 256)));
    test_random(10, 0);
    write_pattern_count(9'd256);
  endtask

  initial begin
    foreach (pat_len[s]) begin
      pat_len[s] = '0;
      loaded_mask[s] = '0;
    end
    foreach (lo_map[i]) begin
      lo_map[i] = '0;
      hi_map[i] = '0;
    end
    pat_count = '0;
    clear_search();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_init();
    test_directed();
    test_count_settings();
    test_random(15, 0);
    test_random(15, 88);
    test_pause_then_resume();
    test_random(15, 31);
    test_random(10, 0);

    drain();
    $display("Sent %0d requests; checked %0d matches and %0d no-match results.",
             n_reqs, n_found, n_nomatch);
    $display("Pattern counts 0, 1, 256 and saturated; idle phases 0/31/88 percent.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
